FILE: src/spf_pkg.sv
// Package for the scanline polygon span fill block.
// Holds the span limit and the transaction kind codes; no dependencies.
`default_nettype none
package spf_pkg;
    localparam int SPAN_LIMIT = 8;
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_QUERY = 1'b1;
endpackage
`default_nettype wire

FILE: src/spf_ram.sv
// Generic single-port RAM with registered read for the span fill block.
// No dependencies.
`default_nettype none
module spf_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

FILE: src/spf_div.sv
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// No dependencies.
`default_nettype none
module spf_div #(
    parameter int NW = 26,
    parameter int DW = 14
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic signed [NW-1:0] num,
    input  wire logic signed [DW-1:0] den,
    output logic                      done,
    output logic signed [NW-1:0]      quot
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [DW:0]   trial;

    always_comb begin
        trial  = {r_reg[DW-1:0], q_reg[NW-1]};
        r_next = trial;
        q_next = {q_reg[NW-2:0], 1'b0};
        if (trial >= {1'b0, d_reg}) begin
            r_next = trial - {1'b0, d_reg};
            q_next[0] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        done <= 1'b0;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NW);
            q_reg    <= num[NW-1] ? NW'(-num) : num;
            d_reg    <= den[DW-1] ? DW'(-den) : den;
            neg_reg  <= num[NW-1] ^ den[DW-1];
            r_reg    <= '0;
        end else if (busy_reg) begin
            q_reg   <= q_next;
            r_reg   <= r_next;
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
                done     <= 1'b1;
            end
        end
    end
    assign quot = neg_reg ? NW'(-q_reg) : q_reg;
endmodule
`default_nettype wire

FILE: src/scanline_polygon_span_fill.sv
// Top level of the scanline polygon span fill block.
// Depends on spf_pkg, spf_ram and spf_div.
`default_nettype none
// A load transaction writes one vertex and gives no result.
// A query transaction walks every edge of the polygon: two RAM reads and a
// crossing test per edge. Each crossing edge adds a multiply and a serial
// divide in the shared divider (2*COORD_BITS+2 quotient bits, one per
// cycle), then an insertion sort of the new crossing (one compare-and-shift
// per cycle, then a final step that drops it in). Spans then leave one per
// cycle while m_ready is high; the block is not ready during a query. An
// empty row gives one result with has_span low and last high.
module scanline_polygon_span_fill #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_BITS   = 12
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [4:0]                   cfg_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_kind,
    input  wire logic [3:0]                   s_vertex_index,
    input  wire logic signed [COORD_BITS-1:0] s_vertex_x,
    input  wire logic signed [COORD_BITS-1:0] s_vertex_y,
    input  wire logic signed [COORD_BITS-1:0] s_scan_row,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [COORD_BITS-1:0]      m_span_row,
    output logic signed [COORD_BITS-1:0]      m_span_x_start,
    output logic signed [COORD_BITS-1:0]      m_span_x_end,
    output logic                              m_has_span,
    output logic                              m_last
);
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NB = $clog2(MAX_VERTICES + 1);
    localparam int CB = COORD_BITS;
    localparam int NW = 2 * CB + 2;
    localparam int DW = CB + 2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD_A, ST_RD_B, ST_TEST, ST_DIV_GO, ST_DIV_WAIT,
        ST_INS, ST_NEXT, ST_OUT
    } state_t;

    state_t state_reg;
    logic [4:0] vcount_reg;
    logic [NB-1:0] n_lim;
    logic signed [CB-1:0] row_reg;
    logic [NB-1:0] edge_reg, nx_reg, pos_reg, pairs_reg, k_reg;
    logic signed [CB-1:0] x1_reg, y1_reg;
    logic signed [CB-1:0] xs_reg [MAX_VERTICES];
    logic signed [CB-1:0] xnew_reg;

    logic ram_we;
    logic [AW-1:0] ram_addr;
    logic signed [CB-1:0] rx, ry;
    logic div_start, div_done;
    logic signed [NW-1:0] div_num, div_quot;
    logic signed [DW-1:0] div_den;

    // Clamp the vertex count into the legal range.
    always_comb begin
        if (vcount_reg < 5'd3) n_lim = NB'(3);
        else if (32'(vcount_reg) > MAX_VERTICES) n_lim = NB'(MAX_VERTICES);
        else n_lim = NB'(vcount_reg);
    end

    assign ram_we = (state_reg == ST_IDLE) && s_valid && s_kind == spf_pkg::KIND_LOAD
                    && 32'(s_vertex_index) < MAX_VERTICES;
    always_comb begin
        if (state_reg == ST_IDLE) ram_addr = AW'(s_vertex_index);
        else if (state_reg == ST_RD_A) ram_addr = AW'(edge_reg);
        else ram_addr = (edge_reg + 1'b1 == n_lim) ? '0 : AW'(edge_reg + 1'b1);
    end

    spf_ram #(.WIDTH(CB), .DEPTH(MAX_VERTICES)) u_ram_x (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(s_vertex_x), .rdata(rx));
    spf_ram #(.WIDTH(CB), .DEPTH(MAX_VERTICES)) u_ram_y (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(s_vertex_y), .rdata(ry));

    // Second endpoint sits on the RAM outputs during ST_TEST and after.
    logic signed [CB-1:0] x2_hold_reg, y2_hold_reg;
    logic crosses;
    assign crosses = (row_reg >= y1_reg && row_reg < ry) || (row_reg >= ry && row_reg < y1_reg);

    assign div_num = NW'((CB+1)'(row_reg) - (CB+1)'(y1_reg))
                   * NW'((CB+1)'(x2_hold_reg) - (CB+1)'(x1_reg));
    assign div_den = DW'(y2_hold_reg) - DW'(y1_reg);

    spf_div #(.NW(NW), .DW(DW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(div_num),
        .den(div_den), .done(div_done), .quot(div_quot));
    assign div_start = (state_reg == ST_DIV_GO);

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);

    logic [NB-1:0] pm1;
    assign pm1 = pos_reg - 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            vcount_reg <= 5'd3;
            m_valid    <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (cfg_valid) vcount_reg <= cfg_data;
                    if (s_valid && s_kind == spf_pkg::KIND_QUERY) begin
                        row_reg   <= s_scan_row;
                        edge_reg  <= '0;
                        nx_reg    <= '0;
                        state_reg <= ST_RD_A;
                    end
                end
                ST_RD_A: state_reg <= ST_RD_B;
                ST_RD_B: begin
                    x1_reg <= rx;
                    y1_reg <= ry;
                    state_reg <= ST_TEST;
                end
                ST_TEST: begin
                    x2_hold_reg <= rx;
                    y2_hold_reg <= ry;
                    state_reg <= crosses ? ST_DIV_GO : ST_NEXT;
                end
                ST_DIV_GO: state_reg <= ST_DIV_WAIT;
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        xnew_reg  <= CB'(NW'(x1_reg) + div_quot);
                        pos_reg   <= nx_reg;
                        state_reg <= ST_INS;
                    end
                end
                ST_INS: begin
                    // Shift larger entries up one place, then drop in.
                    if (pos_reg != '0 && xs_reg[AW'(pm1)] > xnew_reg) begin
                        xs_reg[AW'(pos_reg)] <= xs_reg[AW'(pm1)];
                        pos_reg <= pm1;
                    end else begin
                        xs_reg[AW'(pos_reg)] <= xnew_reg;
                        nx_reg <= nx_reg + 1'b1;
                        state_reg <= ST_NEXT;
                    end
                end
                ST_NEXT: begin
                    if (edge_reg + 1'b1 == n_lim) begin
                        pairs_reg <= (nx_reg >> 1) > NB'(spf_pkg::SPAN_LIMIT)
                                   ? NB'(spf_pkg::SPAN_LIMIT) : (nx_reg >> 1);
                        k_reg <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        edge_reg <= edge_reg + 1'b1;
                        state_reg <= ST_RD_A;
                    end
                end
                ST_OUT: begin
                    if (!m_valid || m_ready) begin
                        if (m_valid && m_last) begin
                            m_valid   <= 1'b0;
                            state_reg <= ST_IDLE;
                        end else begin
                            m_valid    <= 1'b1;
                            m_span_row <= row_reg;
                            if (pairs_reg == '0) begin
                                m_has_span     <= 1'b0;
                                m_span_x_start <= '0;
                                m_span_x_end   <= '0;
                                m_last         <= 1'b1;
                            end else begin
                                m_has_span     <= 1'b1;
                                m_span_x_start <= xs_reg[AW'({k_reg, 1'b0})];
                                m_span_x_end   <= xs_reg[AW'({k_reg, 1'b1})];
                                m_last         <= (k_reg + 1'b1 == pairs_reg);
                                k_reg          <= k_reg + 1'b1;
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // Results only appear while the query sequencer is in its output phase.
    a_valid_in_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> state_reg == ST_OUT) else $error("result outside output phase");
    // An empty row result always closes the query.
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_has_span) |-> m_last) else $error("empty result not last");
    // The crossing list never overflows the edge count.
    a_nx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(nx_reg) <= MAX_VERTICES) else $error("crossing count overflow");
`endif
endmodule
`default_nettype wire
